>>> hdl/lprp_pkg.sv
// Shared types, codes and constants of the length-prefixed request parser.
`timescale 1ns / 1ps
`default_nettype none

package lprp_pkg;

    localparam int unsigned LIMIT_W = 25;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 25'd4096;
    localparam logic [LIMIT_W-1:0] LIMIT_CAP = 25'h100_0000;

    localparam logic [2:0] EV_HEADER    = 3'd0;
    localparam logic [2:0] EV_PAYLOAD   = 3'd1;
    localparam logic [2:0] EV_IGNORED   = 3'd2;
    localparam logic [2:0] EV_BAD_COUNT = 3'd3;
    localparam logic [2:0] EV_OVERSIZE  = 3'd4;

    localparam logic [1:0] CMD_UNKNOWN = 2'd0;
    localparam logic [1:0] CMD_SET     = 2'd1;
    localparam logic [1:0] CMD_GET     = 2'd2;
    localparam logic [1:0] CMD_DEL     = 2'd3;

    localparam logic [1:0] VER_OK        = 2'd0;
    localparam logic [1:0] VER_BAD_ARGS  = 2'd1;
    localparam logic [1:0] VER_UNKNOWN   = 2'd2;

    // Command names, indexed by command slot (set, get, del) and character position.
    localparam logic [2:0][2:0][7:0] CMD_WORDS = '{
        '{8'h6C, 8'h65, 8'h64},
        '{8'h74, 8'h65, 8'h67},
        '{8'h74, 8'h65, 8'h73}
    };

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
    } lprp_item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] data_byte;
        logic [1:0] string_index;
        logic       string_end;
        logic       request_done;
        logic [1:0] command;
        logic [1:0] verdict;
    } lprp_result_t;

endpackage

`default_nettype wire

>>> hdl/lprp_if.sv
// Valid/ready channel interfaces for the request byte stream and the result stream.
`timescale 1ns / 1ps
`default_nettype none

interface lprp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, in_byte, restart, input ready);
    modport sink (input valid, in_byte, restart, output ready);
endinterface

interface lprp_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_res;
    logic [7:0] data_byte;
    logic [1:0] string_index;
    logic       string_end;
    logic       request_done;
    logic [1:0] command;
    logic [1:0] verdict;

    modport source (output valid, event_res, data_byte, string_index, string_end,
                    request_done, command, verdict, input ready);
    modport sink (input valid, event_res, data_byte, string_index, string_end,
                  request_done, command, verdict, output ready);
endinterface

`default_nettype wire

>>> hdl/lprp_apb_regs.sv
// APB configuration register holding the request size limit.
`timescale 1ns / 1ps
`default_nettype none

module lprp_apb_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output logic [lprp_pkg::LIMIT_W-1:0]    max_request_bytes
);

    logic [lprp_pkg::LIMIT_W-1:0] limit_reg;
    logic                         wr_en;

    assign wr_en = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= lprp_pkg::LIMIT_RESET;
        end
        else if (wr_en)
        begin
            limit_reg <= pwdata[lprp_pkg::LIMIT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        if (paddr[2] == 1'b0)
        begin
            prdata = {{(32 - lprp_pkg::LIMIT_W){1'b0}}, limit_reg};
        end
    end

    assign pready = 1'b1;
    assign max_request_bytes = limit_reg;

endmodule

`default_nettype wire

>>> hdl/lprp_parser.sv
// Parser state and the single-pass step logic that turns one byte into one result.
`timescale 1ns / 1ps
`default_nettype none

module lprp_parser (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            step,
    input  wire lprp_pkg::lprp_item_t            item,
    input  wire logic [lprp_pkg::LIMIT_W-1:0]    max_request_bytes,
    output lprp_pkg::lprp_result_t               res
);

    localparam logic [1:0] PH_COUNT   = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;
    localparam logic [1:0] PH_FATAL   = 2'd3;

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [31:0] hdr_shift_reg, hdr_shift_next;
    logic [1:0]  str_exp_reg, str_exp_next;
    logic [1:0]  cur_str_reg, cur_str_next;
    logic [23:0] payload_left_reg, payload_left_next;
    logic [24:0] req_bytes_reg, req_bytes_next;
    logic [1:0]  name_pos_reg, name_pos_next;
    logic [2:0]  name_match_reg, name_match_next;

    logic [lprp_pkg::LIMIT_W-1:0] limit;
    logic [31:0]                  len;
    logic [25:0]                  total;
    logic                         oversize;
    logic                         end_flag;

    assign limit = (max_request_bytes > lprp_pkg::LIMIT_CAP) ? lprp_pkg::LIMIT_CAP
                                                             : max_request_bytes;

    always_comb
    begin
        phase_next        = phase_reg;
        hdr_cnt_next      = hdr_cnt_reg;
        hdr_shift_next    = hdr_shift_reg;
        str_exp_next      = str_exp_reg;
        cur_str_next      = cur_str_reg;
        payload_left_next = payload_left_reg;
        req_bytes_next    = req_bytes_reg;
        name_pos_next     = name_pos_reg;
        name_match_next   = name_match_reg;
        res               = '0;
        len               = 32'd0;
        total             = 26'd0;
        oversize          = 1'b0;
        end_flag          = 1'b0;

        if (item.restart)
        begin
            phase_next        = PH_COUNT;
            hdr_cnt_next      = 2'd0;
            hdr_shift_next    = 32'd0;
            str_exp_next      = 2'd0;
            cur_str_next      = 2'd0;
            payload_left_next = 24'd0;
            req_bytes_next    = 25'd0;
            name_pos_next     = 2'd0;
            name_match_next   = 3'd0;
        end

        if (phase_next == PH_FATAL)
        begin
            res.event_res = lprp_pkg::EV_IGNORED;
        end
        else
        begin
            req_bytes_next = req_bytes_next + 25'd1;
            if (phase_next == PH_PAYLOAD)
            begin
                res.event_res    = lprp_pkg::EV_PAYLOAD;
                res.data_byte    = item.in_byte;
                res.string_index = cur_str_next;
                if (cur_str_next == 2'd0)
                begin
                    if (name_pos_next != 2'd3)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            if (lprp_pkg::CMD_WORDS[k][name_pos_next] != item.in_byte)
                            begin
                                name_match_next[k] = 1'b0;
                            end
                        end
                        name_pos_next = name_pos_next + 2'd1;
                    end
                    else
                    begin
                        name_match_next = 3'd0;
                    end
                end
                payload_left_next = payload_left_next - 24'd1;
                end_flag = (payload_left_next == 24'd0);
            end
            else
            begin
                hdr_shift_next   = {hdr_shift_next[23:0], item.in_byte};
                res.event_res    = lprp_pkg::EV_HEADER;
                res.string_index = (phase_next == PH_LENGTH) ? cur_str_next : 2'd0;
                if (hdr_cnt_next != 2'd3)
                begin
                    hdr_cnt_next = hdr_cnt_next + 2'd1;
                end
                else
                begin
                    hdr_cnt_next = 2'd0;
                    if (phase_next == PH_COUNT)
                    begin
                        if (hdr_shift_next != 32'd2 && hdr_shift_next != 32'd3)
                        begin
                            phase_next    = PH_FATAL;
                            res.event_res = lprp_pkg::EV_BAD_COUNT;
                        end
                        else
                        begin
                            str_exp_next    = hdr_shift_next[1:0];
                            cur_str_next    = 2'd0;
                            name_pos_next   = 2'd0;
                            name_match_next = 3'b111;
                            phase_next      = PH_LENGTH;
                            hdr_shift_next  = 32'd0;
                        end
                    end
                    else
                    begin
                        len            = hdr_shift_next;
                        hdr_shift_next = 32'd0;
                        total    = {1'b0, req_bytes_next} + {1'b0, len[24:0]};
                        oversize = len[31] || (len[30:25] != 6'd0) || (total > {1'b0, limit});
                        if (oversize)
                        begin
                            phase_next    = PH_FATAL;
                            res           = '0;
                            res.event_res = lprp_pkg::EV_OVERSIZE;
                        end
                        else if (len == 32'd0)
                        begin
                            end_flag = 1'b1;
                        end
                        else
                        begin
                            payload_left_next = len[23:0];
                            phase_next        = PH_PAYLOAD;
                        end
                    end
                end
            end

            if (end_flag)
            begin
                res.string_end = 1'b1;
                if (cur_str_next == 2'd0 && name_pos_next != 2'd3)
                begin
                    name_match_next = 3'd0;
                end
                cur_str_next = cur_str_next + 2'd1;
                if (cur_str_next == str_exp_next)
                begin
                    res.request_done = 1'b1;
                    res.command      = lprp_pkg::CMD_UNKNOWN;
                    res.verdict      = lprp_pkg::VER_UNKNOWN;
                    if (name_match_next[0])
                    begin
                        res.command = lprp_pkg::CMD_SET;
                        res.verdict = (str_exp_next == 2'd3) ? lprp_pkg::VER_OK
                                                             : lprp_pkg::VER_BAD_ARGS;
                    end
                    else if (name_match_next[1])
                    begin
                        res.command = lprp_pkg::CMD_GET;
                        res.verdict = (str_exp_next == 2'd2) ? lprp_pkg::VER_OK
                                                             : lprp_pkg::VER_BAD_ARGS;
                    end
                    else if (name_match_next[2])
                    begin
                        res.command = lprp_pkg::CMD_DEL;
                        res.verdict = (str_exp_next == 2'd2) ? lprp_pkg::VER_OK
                                                             : lprp_pkg::VER_BAD_ARGS;
                    end
                    phase_next        = PH_COUNT;
                    hdr_cnt_next      = 2'd0;
                    hdr_shift_next    = 32'd0;
                    str_exp_next      = 2'd0;
                    cur_str_next      = 2'd0;
                    payload_left_next = 24'd0;
                    req_bytes_next    = 25'd0;
                    name_pos_next     = 2'd0;
                    name_match_next   = 3'd0;
                end
                else
                begin
                    phase_next     = PH_LENGTH;
                    hdr_cnt_next   = 2'd0;
                    hdr_shift_next = 32'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_COUNT;
            hdr_cnt_reg      <= 2'd0;
            hdr_shift_reg    <= 32'd0;
            str_exp_reg      <= 2'd0;
            cur_str_reg      <= 2'd0;
            payload_left_reg <= 24'd0;
            req_bytes_reg    <= 25'd0;
            name_pos_reg     <= 2'd0;
            name_match_reg   <= 3'd0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            hdr_cnt_reg      <= hdr_cnt_next;
            hdr_shift_reg    <= hdr_shift_next;
            str_exp_reg      <= str_exp_next;
            cur_str_reg      <= cur_str_next;
            payload_left_reg <= payload_left_next;
            req_bytes_reg    <= req_bytes_next;
            name_pos_reg     <= name_pos_next;
            name_match_reg   <= name_match_next;
        end
    end

    // A fatal event must leave the parser locked.
    a_fatal_locks: assert property (@(posedge clk) disable iff (!rst_n)
        step && (res.event_res == lprp_pkg::EV_BAD_COUNT ||
                 res.event_res == lprp_pkg::EV_OVERSIZE)
        |=> phase_reg == PH_FATAL)
        else $error("fatal event did not lock the parser");

    // While in a payload there is always at least one byte left to take.
    a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAYLOAD |-> payload_left_reg != 24'd0)
        else $error("payload phase with nothing left");

    // Once past the count header, the expected string count is two or three.
    a_str_exp: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_LENGTH || phase_reg == PH_PAYLOAD)
        |-> (str_exp_reg == 2'd2 || str_exp_reg == 2'd3))
        else $error("string count out of range after header");

endmodule

`default_nettype wire

>>> hdl/length_prefixed_request_parser.sv
// Top level of the length-prefixed request parser.
// The block takes a request byte stream on byte_stream, one byte per item, and
// gives exactly one result item per byte on result_stream. Both channels use
// valid/ready; an item moves at a rising edge where both are high. Each input
// item also carries restart, which clears the parser and any error lock before
// that byte is parsed.
// A byte accepted on byte_stream is held in the input register and parsed
// from there; its result is loaded into the output register, from which it
// is offered on result_stream. One item is accepted in every cycle while the
// receiver keeps up; the parse step between the input and output registers
// is combinational.
// When the receiver stalls, the result waits in the output register and the
// next byte still enters the input register; only when both are full does
// byte_stream.ready drop.
// The APB port holds max_request_bytes at address 0; the user must write it
// only while the block is idle, which the block does not enforce. Reset clears
// the pipeline valid flags and parser state and sets the limit to 4096 bytes.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_request_parser (
    input  wire logic         clk,
    input  wire logic         rst_n,
    lprp_byte_if.sink         byte_stream,
    lprp_result_if.source     result_stream,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic                          in_valid_reg;
    lprp_pkg::lprp_item_t          in_item_reg;
    logic                          out_valid_reg;
    lprp_pkg::lprp_result_t        out_res_reg;
    lprp_pkg::lprp_result_t        step_res;
    logic [lprp_pkg::LIMIT_W-1:0]  max_request_bytes;
    logic                          advance;
    logic                          accept;

    assign advance = in_valid_reg && (!out_valid_reg || result_stream.ready);
    assign byte_stream.ready = !in_valid_reg || advance;
    assign accept = byte_stream.valid && byte_stream.ready;

    lprp_apb_regs u_regs (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .max_request_bytes (max_request_bytes)
    );

    lprp_parser u_parser (
        .clk               (clk),
        .rst_n             (rst_n),
        .step              (advance),
        .item              (in_item_reg),
        .max_request_bytes (max_request_bytes),
        .res               (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_stream.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_item_reg.in_byte <= byte_stream.in_byte;
            in_item_reg.restart <= byte_stream.restart;
        end
        if (advance)
        begin
            out_res_reg <= step_res;
        end
    end

    assign result_stream.valid        = out_valid_reg;
    assign result_stream.event_res    = out_res_reg.event_res;
    assign result_stream.data_byte    = out_res_reg.data_byte;
    assign result_stream.string_index = out_res_reg.string_index;
    assign result_stream.string_end   = out_res_reg.string_end;
    assign result_stream.request_done = out_res_reg.request_done;
    assign result_stream.command      = out_res_reg.command;
    assign result_stream.verdict      = out_res_reg.verdict;

    // A buffered byte that cannot move on must stay in the input register.
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_item_reg))
        else $error("input register lost a waiting item");

    // A completed request always closes its last string.
    a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.request_done |-> out_res_reg.string_end)
        else $error("request done without string end");

    // Only payload items carry a data byte.
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_res_reg.event_res != lprp_pkg::EV_PAYLOAD
        |-> out_res_reg.data_byte == 8'd0)
        else $error("data byte set on a non-payload item");

endmodule

`default_nettype wire
